[sv/okvt_pkg.sv]
// ----------------------------------------------------------------------------
// Ordered key/value table package
// Shared widths, operation and status codes, and the control word that
// travels with an item along the row of table cells.
// ----------------------------------------------------------------------------
`default_nettype none

package okvt_pkg;

    localparam int DATA_W   = 32;
    localparam int OPCODE_W = 3;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    localparam int DEFAULT_CAPACITY    = 16;
    localparam int DEFAULT_KEY_WIDTH   = 32;
    localparam int DEFAULT_VALUE_WIDTH = 32;

    localparam logic [OPCODE_W-1:0] OP_LOOKUP       = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_ENTER        = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_REMOVE_VALUE = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_REMOVE_KEY   = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_CLEAR        = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOKEY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic                vld;
        logic [OPCODE_W-1:0] op;
        logic                hit;
        logic                del;
        logic                done;
    } t_tok_ctl;

endpackage

`default_nettype wire

[sv/okvt_if.sv]
// ----------------------------------------------------------------------------
// Ordered key/value table channels
// Request and response channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface okvt_req_if;
    logic                          valid;
    logic                          ready;
    logic [okvt_pkg::OPCODE_W-1:0] opcode;
    logic [okvt_pkg::DATA_W-1:0]   key_in;
    logic [okvt_pkg::DATA_W-1:0]   value_in;

    modport source (output valid, output opcode, output key_in, output value_in,
                     input ready);
    modport sink   (input valid, input opcode, input key_in, input value_in,
                     output ready);
endinterface

interface okvt_rsp_if #(
    parameter int CNT_W = okvt_pkg::COUNT_W
);
    logic                          valid;
    logic                          ready;
    logic                          found;
    logic [okvt_pkg::DATA_W-1:0]   value_out;
    logic [okvt_pkg::STATUS_W-1:0] status;
    logic [CNT_W-1:0]              entry_count;

    modport source (output valid, output found, output value_out, output status,
                     output entry_count, input ready);
    modport sink   (input valid, input found, input value_out, input status,
                     input entry_count, output ready);
endinterface

`default_nettype wire

[sv/okvt_cell.sv]
// ----------------------------------------------------------------------------
// Ordered key/value table cell
// Holds one table entry and steps the item passing through it one place on.
// ----------------------------------------------------------------------------
`default_nettype none

module okvt_cell #(
    parameter int KEY_WIDTH   = okvt_pkg::DEFAULT_KEY_WIDTH,
    parameter int VALUE_WIDTH = okvt_pkg::DEFAULT_VALUE_WIDTH
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire okvt_pkg::t_tok_ctl     i_ctl,
    input  wire logic [KEY_WIDTH-1:0]   i_key,
    input  wire logic [VALUE_WIDTH-1:0] i_value,
    input  wire logic [VALUE_WIDTH-1:0] i_vout,
    input  wire logic                   i_nb_valid,
    input  wire logic [KEY_WIDTH-1:0]   i_nb_key,
    input  wire logic [VALUE_WIDTH-1:0] i_nb_value,
    output okvt_pkg::t_tok_ctl          o_ctl,
    output logic [KEY_WIDTH-1:0]        o_key,
    output logic [VALUE_WIDTH-1:0]      o_value,
    output logic [VALUE_WIDTH-1:0]      o_vout,
    output logic                        o_ent_valid,
    output logic [KEY_WIDTH-1:0]        o_ent_key,
    output logic [VALUE_WIDTH-1:0]      o_ent_value
);

    logic                   r_valid, n_valid;
    logic [KEY_WIDTH-1:0]   r_key, n_key;
    logic [VALUE_WIDTH-1:0] r_value, n_value;
    okvt_pkg::t_tok_ctl     r_ctl, n_ctl;
    logic [KEY_WIDTH-1:0]   r_tkey;
    logic [VALUE_WIDTH-1:0] r_tvalue;
    logic [VALUE_WIDTH-1:0] r_vout, n_vout;
    logic                   w_match_key, w_match_val;

    assign w_match_key = r_valid && (r_key == i_key);
    assign w_match_val = r_valid && (r_value == i_value);

    always_comb begin
        n_valid = r_valid;
        n_key   = r_key;
        n_value = r_value;
        n_ctl   = i_ctl;
        n_vout  = i_vout;
        if (i_ctl.vld) begin
            unique case (i_ctl.op) inside
                okvt_pkg::OP_LOOKUP: begin
                    if (!i_ctl.hit && w_match_key) begin
                        n_ctl.hit = 1'b1;
                        n_vout    = r_value;
                    end
                end
                okvt_pkg::OP_ENTER: begin
                    if (!i_ctl.hit && w_match_key) begin
                        n_ctl.hit = 1'b1;
                        n_value   = i_value;
                    end else if (!i_ctl.hit && !i_ctl.done && !r_valid) begin
                        n_ctl.done = 1'b1;
                        n_valid    = 1'b1;
                        n_key      = i_key;
                        n_value    = i_value;
                    end
                end
                okvt_pkg::OP_REMOVE_VALUE, okvt_pkg::OP_REMOVE_KEY: begin
                    if (i_ctl.del || (i_ctl.op == okvt_pkg::OP_REMOVE_VALUE
                                      ? w_match_val : w_match_key)) begin
                        n_ctl.hit = 1'b1;
                        n_ctl.del = 1'b1;
                        n_valid   = i_nb_valid;
                        n_key     = i_nb_key;
                        n_value   = i_nb_value;
                    end
                end
                okvt_pkg::OP_CLEAR: begin
                    n_valid = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_ctl   <= '0;
        end else begin
            r_valid <= n_valid;
            r_ctl   <= n_ctl;
        end
        r_key    <= n_key;
        r_value  <= n_value;
        r_tkey   <= i_key;
        r_tvalue <= i_value;
        r_vout   <= n_vout;
    end

    assign o_ctl       = r_ctl;
    assign o_key       = r_tkey;
    assign o_value     = r_tvalue;
    assign o_vout      = r_vout;
    assign o_ent_valid = r_valid;
    assign o_ent_key   = r_key;
    assign o_ent_value = r_value;

    a_enter_fills_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.vld && i_ctl.op == okvt_pkg::OP_ENTER && !i_ctl.hit && !i_ctl.done
         && !r_valid) |=> (r_valid && r_ctl.done))
        else $error("enter did not fill the first free entry");

    a_remove_shifts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.vld && i_ctl.del) |=> (r_valid == $past(i_nb_valid)))
        else $error("removal did not close the gap");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.vld && i_ctl.op == okvt_pkg::OP_CLEAR) |=> !r_valid)
        else $error("clear left an entry valid");

endmodule

`default_nettype wire

[sv/ordered_key_value_table_top.sv]
// ----------------------------------------------------------------------------
// Ordered key/value table
// Row of CAPACITY entry cells holding unique keys in insertion order.
// ----------------------------------------------------------------------------
// Each item steps through the row of cells one cell per cycle, and its result
// is registered once it leaves the last cell. The block works on one item at
// a time. A new item may be accepted in the cycle in which the previous result
// is taken. Keys and values are held in KEY_WIDTH and VALUE_WIDTH bits; wider
// input bits are dropped.
`default_nettype none

module ordered_key_value_table_top #(
    parameter int CAPACITY    = okvt_pkg::DEFAULT_CAPACITY,
    parameter int KEY_WIDTH   = okvt_pkg::DEFAULT_KEY_WIDTH,
    parameter int VALUE_WIDTH = okvt_pkg::DEFAULT_VALUE_WIDTH
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    okvt_req_if.sink     i_req,
    okvt_rsp_if.source   o_rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    okvt_pkg::t_tok_ctl     w_ctl   [CAPACITY+1];
    logic [KEY_WIDTH-1:0]   w_key   [CAPACITY+1];
    logic [VALUE_WIDTH-1:0] w_value [CAPACITY+1];
    logic [VALUE_WIDTH-1:0] w_vout  [CAPACITY+1];
    logic [CAPACITY-1:0]    w_ent_valid;
    logic [KEY_WIDTH-1:0]   w_ent_key   [CAPACITY];
    logic [VALUE_WIDTH-1:0] w_ent_value [CAPACITY];

    okvt_pkg::t_tok_ctl     r_ctl0;
    logic [KEY_WIDTH-1:0]   r_key0;
    logic [VALUE_WIDTH-1:0] r_value0;
    logic                   r_inflight;
    logic [CNT_W-1:0]       r_count, n_count;
    logic                   r_out_vld;
    logic                   r_out_found;
    logic [okvt_pkg::DATA_W-1:0]   r_out_value;
    logic [okvt_pkg::STATUS_W-1:0] r_out_status, n_status;
    logic                   w_in_acc, w_out_acc;
    okvt_pkg::t_tok_ctl     w_ex;

    assign w_out_acc   = r_out_vld && o_rsp.ready;
    assign i_req.ready = !r_inflight && (!r_out_vld || o_rsp.ready);
    assign w_in_acc    = i_req.valid && i_req.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl0 <= '0;
        end else begin
            r_ctl0 <= '{vld: w_in_acc, op: i_req.opcode, hit: 1'b0, del: 1'b0,
                        done: 1'b0};
        end
        r_key0   <= KEY_WIDTH'(i_req.key_in);
        r_value0 <= VALUE_WIDTH'(i_req.value_in);
    end

    assign w_ctl[0]   = r_ctl0;
    assign w_key[0]   = r_key0;
    assign w_value[0] = r_value0;
    assign w_vout[0]  = '0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic                   w_nb_valid;
        logic [KEY_WIDTH-1:0]   w_nb_key;
        logic [VALUE_WIDTH-1:0] w_nb_value;

        if (g + 1 < CAPACITY) begin : g_nb
            assign w_nb_valid = w_ent_valid[g+1];
            assign w_nb_key   = w_ent_key[g+1];
            assign w_nb_value = w_ent_value[g+1];
        end else begin : g_end
            assign w_nb_valid = 1'b0;
            assign w_nb_key   = '0;
            assign w_nb_value = '0;
        end

        okvt_cell #(
            .KEY_WIDTH   (KEY_WIDTH),
            .VALUE_WIDTH (VALUE_WIDTH)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl[g]),
            .i_key       (w_key[g]),
            .i_value     (w_value[g]),
            .i_vout      (w_vout[g]),
            .i_nb_valid  (w_nb_valid),
            .i_nb_key    (w_nb_key),
            .i_nb_value  (w_nb_value),
            .o_ctl       (w_ctl[g+1]),
            .o_key       (w_key[g+1]),
            .o_value     (w_value[g+1]),
            .o_vout      (w_vout[g+1]),
            .o_ent_valid (w_ent_valid[g]),
            .o_ent_key   (w_ent_key[g]),
            .o_ent_value (w_ent_value[g])
        );
    end

    assign w_ex = w_ctl[CAPACITY];

    always_comb begin
        n_count  = r_count;
        n_status = okvt_pkg::ST_OK;
        unique case (w_ex.op)
            okvt_pkg::OP_ENTER: begin
                if (w_ex.done) begin
                    n_count = r_count + CNT_W'(1);
                end else if (!w_ex.hit) begin
                    n_status = okvt_pkg::ST_FULL;
                end
            end
            okvt_pkg::OP_REMOVE_VALUE: begin
                if (w_ex.hit) begin
                    n_count = r_count - CNT_W'(1);
                end
            end
            okvt_pkg::OP_REMOVE_KEY: begin
                if (w_ex.hit) begin
                    n_count = r_count - CNT_W'(1);
                end else begin
                    n_status = okvt_pkg::ST_NOKEY;
                end
            end
            okvt_pkg::OP_CLEAR: begin
                n_count = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= 1'b0;
            r_out_vld  <= 1'b0;
            r_count    <= '0;
        end else begin
            if (w_in_acc) begin
                r_inflight <= 1'b1;
            end else if (w_ex.vld) begin
                r_inflight <= 1'b0;
            end
            if (w_ex.vld) begin
                r_out_vld <= 1'b1;
                r_count   <= n_count;
            end else if (w_out_acc) begin
                r_out_vld <= 1'b0;
            end
        end
        if (w_ex.vld) begin
            r_out_found  <= w_ex.hit;
            r_out_value  <= okvt_pkg::DATA_W'(w_vout[CAPACITY]);
            r_out_status <= n_status;
        end
    end

    assign o_rsp.valid       = r_out_vld;
    assign o_rsp.found       = r_out_found;
    assign o_rsp.value_out   = r_out_value;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.entry_count = okvt_pkg::COUNT_W'(r_count);

    a_count_tracks_cells: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_inflight |-> (r_count == CNT_W'($countones(w_ent_valid))))
        else $error("entry count differs from the number of valid cells");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_result_from_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(w_ex.vld))
        else $error("result raised without an item leaving the row");

    a_exit_only_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ex.vld |-> r_inflight)
        else $error("item left the row with none in flight");

endmodule

`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered key/value table testbench
// Drives lookup, enter, remove and clear items into the table and keeps a
// table of its own in step with them. Each result is checked field by field
// against the oldest prediction. Both channels idle at random, the response
// side once holds off for a long stretch, and the sender at times waits
// for the table to drain before it goes on.
// ----------------------------------------------------------------------------

module tb;
    import okvt_pkg::*;

    localparam int CAP          = DEFAULT_CAPACITY;
    localparam int KEY_W        = DEFAULT_KEY_WIDTH;
    localparam int VAL_W        = DEFAULT_VALUE_WIDTH;
    localparam int RANDOM_OPS   = 1000;
    localparam int CALM_TAIL    = 150;
    localparam int LONG_HOLD    = 400;
    localparam int HOLD_AFTER   = 300;
    localparam int SETTLE       = 4 * (CAP + 2);
    localparam int LIMIT_CYCLES = 400000;
    localparam int OPCODE_TOP   = (1 << OPCODE_W) - 1;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [DATA_W-1:0]   key_in;
        logic [DATA_W-1:0]   value_in;
        logic                drain_first;
    } table_op_t;

    typedef struct packed {
        logic                found;
        logic [DATA_W-1:0]   value_out;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  entry_count;
    } table_reply_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    okvt_req_if req_ch ();
    okvt_rsp_if rsp_ch ();

    ordered_key_value_table_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    table_op_t    ops_to_send[$];
    table_reply_t replies_due[$];
    table_op_t    on_offer;

    logic [KEY_W-1:0] tbl_key [CAP];
    logic [VAL_W-1:0] tbl_val [CAP];
    int               tbl_fill = 0;

    int total_ops = 0;
    int sent_count = 0;
    int n_results = 0;
    int n_fail = 0;
    int gap_left = 0;
    int stall_left = 0;
    bit long_hold_done = 1'b0;
    int cycle_count = 0;

    function automatic int find_slot(bit by_value, logic [DATA_W-1:0] word);
        for (int i = 0; i < tbl_fill; i++) begin
            if (by_value ? (tbl_val[i] == VAL_W'(word)) : (tbl_key[i] == KEY_W'(word)))
                return i;
        end
        return -1;
    endfunction

    function automatic void drop_entry(int pos);
        for (int i = pos; i + 1 < tbl_fill; i++) begin
            tbl_key[i] = tbl_key[i+1];
            tbl_val[i] = tbl_val[i+1];
        end
        tbl_fill--;
    endfunction

    function automatic table_reply_t table_apply(table_op_t op);
        table_reply_t r;
        int pos;
        r = '0;
        r.status = ST_OK;
        case (op.opcode)
            OP_LOOKUP: begin
                pos = find_slot(1'b0, op.key_in);
                if (pos >= 0) begin
                    r.found = 1'b1;
                    r.value_out = DATA_W'(tbl_val[pos]);
                end
            end
            OP_ENTER: begin
                pos = find_slot(1'b0, op.key_in);
                if (pos >= 0) begin
                    r.found = 1'b1;
                    tbl_val[pos] = VAL_W'(op.value_in);
                end else if (tbl_fill < CAP) begin
                    tbl_key[tbl_fill] = KEY_W'(op.key_in);
                    tbl_val[tbl_fill] = VAL_W'(op.value_in);
                    tbl_fill++;
                end else begin
                    r.status = ST_FULL;
                end
            end
            OP_REMOVE_VALUE: begin
                pos = find_slot(1'b1, op.value_in);
                if (pos >= 0) begin
                    r.found = 1'b1;
                    drop_entry(pos);
                end
            end
            OP_REMOVE_KEY: begin
                pos = find_slot(1'b0, op.key_in);
                if (pos >= 0) begin
                    r.found = 1'b1;
                    drop_entry(pos);
                end else begin
                    r.status = ST_NOKEY;
                end
            end
            OP_CLEAR: tbl_fill = 0;
            default: ;
        endcase
        r.entry_count = COUNT_W'(tbl_fill);
        return r;
    endfunction

    task automatic queue_op(logic [OPCODE_W-1:0] opc, logic [DATA_W-1:0] k,
                            logic [DATA_W-1:0] v, bit drain);
        table_op_t op;
        op.opcode = opc;
        op.key_in = k;
        op.value_in = v;
        op.drain_first = drain;
        ops_to_send.push_back(op);
    endtask

    // Sender: holds an item until it is taken, then idles or moves on.
    always @(posedge i_clk) begin
        table_op_t nxt;
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                replies_due.push_back(table_apply(on_offer));
                sent_count++;
                if (sent_count < total_ops - CALM_TAIL && $urandom_range(0, 4) == 0)
                    gap_left = $urandom_range(1, 13);
            end
            if (req_ch.valid && !req_ch.ready) begin
                req_ch.valid <= 1'b1;
            end else if (gap_left > 0) begin
                gap_left--;
                req_ch.valid <= 1'b0;
            end else if (ops_to_send.size() > 0 &&
                         (!ops_to_send[0].drain_first || sent_count == n_results)) begin
                nxt = ops_to_send.pop_front();
                on_offer = nxt;
                req_ch.valid    <= 1'b1;
                req_ch.opcode   <= nxt.opcode;
                req_ch.key_in   <= nxt.key_in;
                req_ch.value_in <= nxt.value_in;
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // Receiver back-pressure, with one long hold-off part way through.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (!long_hold_done && n_results >= HOLD_AFTER) begin
                long_hold_done = 1'b1;
                stall_left = LONG_HOLD;
            end else if (stall_left == 0 && n_results < total_ops - CALM_TAIL &&
                         $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 13);
            end
            if (stall_left > 0) begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        table_reply_t got;
        table_reply_t want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            got.found = rsp_ch.found;
            got.value_out = rsp_ch.value_out;
            got.status = rsp_ch.status;
            got.entry_count = rsp_ch.entry_count;
            n_results <= n_results + 1;
            if (replies_due.size() == 0) begin
                n_fail++;
                if (n_fail <= 10)
                    $display({"Result %0d arrived with nothing expected: ",
                              "found=%0b value=%h status=%0d count=%0d"},
                             n_results, got.found, got.value_out, got.status,
                             got.entry_count);
            end else begin
                want = replies_due.pop_front();
                if (got.found !== want.found || got.value_out !== want.value_out ||
                    got.status !== want.status || got.entry_count !== want.entry_count) begin
                    n_fail++;
                    if (n_fail <= 10)
                        $display({"Mismatch on result %0d: expected found=%0b value=%h ",
                                  "status=%0d count=%0d, got found=%0b value=%h ",
                                  "status=%0d count=%0d"},
                                 n_results, want.found, want.value_out, want.status,
                                 want.entry_count, got.found, got.value_out, got.status,
                                 got.entry_count);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    initial begin
        logic [DATA_W-1:0]   key_pool [24];
        logic [DATA_W-1:0]   val_pool [4];
        logic [OPCODE_W-1:0] opc;
        logic [DATA_W-1:0]   k;
        logic [DATA_W-1:0]   v;
        int n_real;
        int pool_n;
        int w;
        bit drain;

        req_ch.valid = 1'b0;
        req_ch.opcode = OP_LOOKUP;
        req_ch.key_in = '0;
        req_ch.value_in = '0;
        rsp_ch.ready = 1'b0;

        // Directed: empty table, extremes, update in place, filling up,
        // full table with a new and a known key, removals, unused code, clear.
        queue_op(OP_LOOKUP, '0, '0, 1'b0);
        queue_op(OP_REMOVE_KEY, '1, '0, 1'b0);
        queue_op(OP_REMOVE_VALUE, '0, '1, 1'b0);
        queue_op(OP_ENTER, '0, '0, 1'b0);
        queue_op(OP_ENTER, '1, '1, 1'b0);
        queue_op(OP_ENTER, '0, 32'hA5A5_A5A5, 1'b0);
        queue_op(OP_LOOKUP, '1, '0, 1'b0);
        for (int i = 2; i < CAP; i++)
            queue_op(OP_ENTER, DATA_W'(i * 32'h0101_0101), DATA_W'(i % 3), 1'b0);
        queue_op(OP_ENTER, 32'h1234_5678, 32'h5A5A_5A5A, 1'b1);
        queue_op(OP_ENTER, '1, 32'h0F0F_F0F0, 1'b0);
        queue_op(OP_REMOVE_VALUE, '0, 32'd1, 1'b0);
        queue_op(OP_REMOVE_KEY, 32'h0707_0707, '0, 1'b0);
        queue_op(OP_LOOKUP, 32'h0808_0808, '0, 1'b0);
        queue_op(OP_CLEAR + 3'd1, '1, '1, 1'b0);
        queue_op(OP_CLEAR, '0, '0, 1'b0);
        queue_op(OP_LOOKUP, '1, '0, 1'b0);

        n_real = 0;
        while (n_real < RANDOM_OPS) begin
            if ($urandom_range(0, 6) == 0) begin
                repeat ($urandom_range(3, 10)) begin
                    opc = OPCODE_W'($urandom_range(0, OPCODE_TOP));
                    queue_op(opc, $urandom, $urandom, 1'b0);
                    if (opc <= OP_CLEAR)
                        n_real++;
                end
            end else begin
                pool_n = $urandom_range(4, 24);
                for (int i = 0; i < pool_n; i++)
                    key_pool[i] = ($urandom_range(0, 9) == 0) ?
                                  ($urandom_range(0, 1) ? '1 : '0) : $urandom;
                for (int i = 0; i < 4; i++)
                    val_pool[i] = $urandom;
                drain = ($urandom_range(0, 5) == 0);
                repeat ($urandom_range(15, 40)) begin
                    w = $urandom_range(0, 99);
                    if (w < 40)
                        opc = OP_ENTER;
                    else if (w < 65)
                        opc = OP_LOOKUP;
                    else if (w < 80)
                        opc = OP_REMOVE_KEY;
                    else if (w < 94)
                        opc = OP_REMOVE_VALUE;
                    else if (w < 97)
                        opc = OP_CLEAR;
                    else
                        opc = OPCODE_W'($urandom_range(int'(OP_CLEAR) + 1, OPCODE_TOP));
                    k = ($urandom_range(0, 9) == 0) ?
                        $urandom : key_pool[$urandom_range(0, pool_n - 1)];
                    v = ($urandom_range(0, 3) == 0) ? $urandom : val_pool[$urandom_range(0, 3)];
                    queue_op(opc, k, v, drain);
                    drain = 1'b0;
                    if (opc <= OP_CLEAR)
                        n_real++;
                end
            end
        end
        total_ops = ops_to_send.size();

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(posedge i_clk);
        while (ops_to_send.size() != 0 || req_ch.valid || n_results != sent_count)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        if (n_fail == 0 && replies_due.size() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
